// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the ray box slab test.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define RBST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition at one edge leads to a result at the next edge.
`define RBST_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ----- rtl/rbst_pkg.sv -----
// Package with the payload types, register codes and float helpers of the slab test.
package rbst_pkg;

	typedef struct packed {
		logic [31:0] box_min_x;
		logic [31:0] box_min_y;
		logic [31:0] box_min_z;
		logic [31:0] box_max_x;
		logic [31:0] box_max_y;
		logic [31:0] box_max_z;
	} box_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] t_near;
	} res_t;

	typedef struct packed {
		logic [31:0] t_far;
		logic [31:0] t_near;
	} slab_t;

	localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
	localparam logic [2:0] REG_INV_DIR_X = 3'd3;
	localparam logic [2:0] REG_INV_DIR_Y = 3'd4;
	localparam logic [2:0] REG_INV_DIR_Z = 3'd5;

	localparam logic [31:0] FP_POS_INF = 32'h7F80_0000;
	localparam logic [31:0] FP_NEG_INF = 32'hFF80_0000;
	localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;
	localparam logic [31:0] FP_ZERO    = 32'h0000_0000;

	// IEEE less-than for operands that are not NaN; the two zeros compare equal.
	function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
		logic res;
		begin
			if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
				res = 1'b0;
			end else if (a[31] != b[31]) begin
				res = a[31];
			end else if (!a[31]) begin
				res = a[30:0] < b[30:0];
			end else begin
				res = a[30:0] > b[30:0];
			end
			return res;
		end
	endfunction

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		begin
			n = 5'd27;
			for (int i = 0; i < 27; i++) begin
				if (v[i]) begin
					n = 5'(26 - i);
				end
			end
			return n;
		end
	endfunction

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		begin
			n = 6'd48;
			for (int i = 0; i < 48; i++) begin
				if (v[i]) begin
					n = 6'(47 - i);
				end
			end
			return n;
		end
	endfunction

endpackage

// ----- rtl/rbst_fsub.sv -----
// Two-stage binary32 subtractor with round to nearest even and subnormals.
module rbst_fsub (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [1:0]  en,
	output logic [31:0] y
);
	import rbst_pkg::*;

	logic        sa, sb, a_nan, b_nan, a_inf, b_inf, swap;
	logic [31:0] big, sml;
	logic [7:0]  eb, es, d;
	logic [23:0] mb, ms;
	logic [26:0] ext, shf, mask;
	logic        stk;
	logic [27:0] sum;

	logic [27:0] sum_s1;
	logic [7:0]  e_s1;
	logic        sign_s1, nan_s1, inf_s1, infsign_s1, zsign_s1;

	logic [4:0]  lz;
	logic [7:0]  lim, shl;
	logic [26:0] norm;
	logic [8:0]  enew, efield;
	logic        inc;
	logic [30:0] mag;
	logic [31:0] res;

	always_comb begin
		sa    = a[31];
		sb    = ~b[31];
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		swap  = b[30:0] > a[30:0];
		big   = swap ? {sb, b[30:0]} : {sa, a[30:0]};
		sml   = swap ? {sa, a[30:0]} : {sb, b[30:0]};
		eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		mb    = {big[30:23] != 8'd0, big[22:0]};
		ms    = {sml[30:23] != 8'd0, sml[22:0]};
		d     = eb - es;
		ext   = {ms, 3'b000};
		mask  = (27'd1 << d[4:0]) - 27'd1;
		if (d < 8'd27) begin
			shf = ext >> d[4:0];
			stk = |(ext & mask);
		end else begin
			shf = 27'd0;
			stk = |ms;
		end
		shf[0] = shf[0] | stk;
		if (big[31] != sml[31]) begin
			sum = {1'b0, mb, 3'b000} - {1'b0, shf};
		end else begin
			sum = {1'b0, mb, 3'b000} + {1'b0, shf};
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sum_s1     <= sum;
			e_s1       <= eb;
			sign_s1    <= big[31];
			nan_s1     <= a_nan | b_nan | (a_inf & b_inf & (sa != sb));
			inf_s1     <= a_inf | b_inf;
			infsign_s1 <= a_inf ? sa : sb;
			zsign_s1   <= sa & sb;
		end
	end

	always_comb begin
		lz   = lzc27(sum_s1[26:0]);
		lim  = e_s1 - 8'd1;
		shl  = ({3'b000, lz} < lim) ? {3'b000, lz} : lim;
		if (sum_s1[27]) begin
			norm = {sum_s1[27:2], sum_s1[1] | sum_s1[0]};
			enew = {1'b0, e_s1} + 9'd1;
		end else begin
			norm = sum_s1[26:0] << shl[4:0];
			enew = {1'b0, e_s1} - {1'b0, shl};
		end
		efield = norm[26] ? enew : 9'd0;
		inc    = norm[2] & (norm[3] | norm[1] | norm[0]);
		mag    = {efield[7:0], norm[25:3]} + {30'd0, inc};
		if (nan_s1) begin
			res = FP_QNAN;
		end else if (inf_s1) begin
			res = {infsign_s1, FP_POS_INF[30:0]};
		end else if (sum_s1 == 28'd0) begin
			res = {zsign_s1, 31'd0};
		end else if (efield >= 9'd255) begin
			res = {sign_s1, FP_POS_INF[30:0]};
		end else begin
			res = {sign_s1, mag};
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			y <= res;
		end
	end

endmodule

// ----- rtl/rbst_fmul.sv -----
// Three-stage binary32 multiplier with round to nearest even and subnormals.
module rbst_fmul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [2:0]  en,
	output logic [31:0] y
);
	import rbst_pkg::*;

	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [7:0] ea, eb;

	logic [47:0] prod_s3;
	logic [8:0]  esum_s3;
	logic        sign_s3, nan_s3, inf_s3, zero_s3;

	logic [5:0]         lz;
	logic signed [10:0] ex, lsh;
	logic [5:0]         shl, shr;
	logic [7:0]         efld;

	logic [47:0] prod_s4;
	logic [5:0]  shl_s4, shr_s4;
	logic [7:0]  efld_s4;
	logic        ovf_s4, sign_s4, nan_s4, inf_s4, zero_s4;

	logic [47:0] left, rs;
	logic [63:0] wide, mask;
	logic        stk, inc;
	logic [30:0] mag;
	logic [31:0] res;

	always_comb begin
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = a[30:0] == 31'd0;
		b_zero = b[30:0] == 31'd0;
		ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s3 <= {a[30:23] != 8'd0, a[22:0]} * {b[30:23] != 8'd0, b[22:0]};
			esum_s3 <= {1'b0, ea} + {1'b0, eb};
			sign_s3 <= a[31] ^ b[31];
			nan_s3  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
			inf_s3  <= a_inf | b_inf;
			zero_s3 <= a_zero | b_zero;
		end
	end

	always_comb begin
		lz  = lzc48(prod_s3);
		ex  = $signed({2'b00, esum_s3}) - 11'sd126 - $signed({5'd0, lz});
		lsh = $signed({5'd0, lz}) + ex - 11'sd1;
		if (ex >= 11'sd1) begin
			shl  = lz;
			shr  = 6'd0;
			efld = (ex >= 11'sd255) ? 8'hFF : ex[7:0];
		end else begin
			efld = 8'd0;
			if (lsh >= 11'sd0) begin
				shl = lsh[5:0];
				shr = 6'd0;
			end else begin
				shl = 6'd0;
				shr = (lsh < -11'sd63) ? 6'd63 : 6'(-lsh);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s4 <= prod_s3;
			shl_s4  <= shl;
			shr_s4  <= shr;
			efld_s4 <= efld;
			ovf_s4  <= ex >= 11'sd255;
			sign_s4 <= sign_s3;
			nan_s4  <= nan_s3;
			inf_s4  <= inf_s3;
			zero_s4 <= zero_s3;
		end
	end

	always_comb begin
		left = prod_s4 << shl_s4;
		rs   = left >> shr_s4;
		wide = {16'd0, left};
		mask = (64'd1 << shr_s4) - 64'd1;
		stk  = (|rs[22:0]) | (|(wide & mask));
		inc  = rs[23] & (stk | rs[24]);
		mag  = {(rs[47] ? efld_s4 : 8'd0), rs[46:24]} + {30'd0, inc};
		if (nan_s4) begin
			res = FP_QNAN;
		end else if (inf_s4 || ovf_s4) begin
			res = {sign_s4, FP_POS_INF[30:0]};
		end else if (zero_s4) begin
			res = {sign_s4, FP_ZERO[30:0]};
		end else begin
			res = {sign_s4, mag};
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			y <= res;
		end
	end

endmodule

// ----- rtl/rbst_lane.sv -----
// One axis lane: two differences, two products and the far and near picks.
module rbst_lane (
	input  logic                 clk,
	input  logic [31:0]          lo,
	input  logic [31:0]          hi,
	input  logic [31:0]          origin,
	input  logic [31:0]          inv_dir,
	input  logic [4:0]           en,
	output rbst_pkg::slab_t      slab
);
	import rbst_pkg::*;

	logic [31:0] d_lo, d_hi, p_lo, p_hi;
	logic [31:0] f_lo, f_hi, n_lo, n_hi;
	logic        nan_lo, nan_hi;

	rbst_fsub u_sub_lo (.clk(clk), .a(lo), .b(origin), .en(en[1:0]), .y(d_lo));
	rbst_fsub u_sub_hi (.clk(clk), .a(hi), .b(origin), .en(en[1:0]), .y(d_hi));
	rbst_fmul u_mul_lo (.clk(clk), .a(d_lo), .b(inv_dir), .en(en[4:2]), .y(p_lo));
	rbst_fmul u_mul_hi (.clk(clk), .a(d_hi), .b(inv_dir), .en(en[4:2]), .y(p_hi));

	always_comb begin
		nan_lo      = (p_lo[30:23] == 8'hFF) && (p_lo[22:0] != 23'd0);
		nan_hi      = (p_hi[30:23] == 8'hFF) && (p_hi[22:0] != 23'd0);
		f_lo        = nan_lo ? FP_POS_INF : p_lo;
		f_hi        = nan_hi ? FP_POS_INF : p_hi;
		n_lo        = nan_lo ? FP_NEG_INF : p_lo;
		n_hi        = nan_hi ? FP_NEG_INF : p_hi;
		slab.t_far  = fp_lt(f_hi, f_lo) ? f_lo : f_hi;
		slab.t_near = fp_lt(n_lo, n_hi) ? n_lo : n_hi;
	end

endmodule

// ----- rtl/ray_box_slab_test_top.sv -----
// Top level of the ray against axis-aligned box slab test.
//
// The ray origin and inverse direction sit in six configuration registers,
// written through cfg_we, cfg_index and cfg_data. The user must write them
// only while the block is idle; the block itself does not enforce this.
// Each input transfer carries one box as binary32 corners; each box gives
// exactly one output transfer with the hit flag and the entry parameter.
// Three axis lanes each run two subtractors and two multipliers in parallel,
// and a merge stage reduces the per-axis far and near values. A box passes
// two subtractor stages, three multiplier stages and the merge register.
// Throughput is one box per cycle unless stalled; stages are independent.
// When the receiver stalls, a finished result holds in the output register
// and the stages behind it keep filling until each holds an item; only then
// does in_stall rise. Reset clears every stage valid and sets all
// configuration registers to zero.
module ray_box_slab_test_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  rbst_pkg::box_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output rbst_pkg::res_t out_data
);
	import rbst_pkg::*;
	`include "assert_macros.svh"

	logic [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic [31:0] inv_dir_x_q, inv_dir_y_q, inv_dir_z_q;
	logic [6:1]  v_q;
	logic [6:1]  load;
	slab_t       sx, sy, sz;
	logic [31:0] far_xy, far_all, near_xy, near_all;
	res_t        res;
	res_t        out_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= 32'd0;
			origin_y_q  <= 32'd0;
			origin_z_q  <= 32'd0;
			inv_dir_x_q <= 32'd0;
			inv_dir_y_q <= 32'd0;
			inv_dir_z_q <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X:  origin_x_q  <= cfg_data;
				REG_ORIGIN_Y:  origin_y_q  <= cfg_data;
				REG_ORIGIN_Z:  origin_z_q  <= cfg_data;
				REG_INV_DIR_X: inv_dir_x_q <= cfg_data;
				REG_INV_DIR_Y: inv_dir_y_q <= cfg_data;
				REG_INV_DIR_Z: inv_dir_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		load[6] = !v_q[6] || !out_stall;
		for (int k = 5; k >= 1; k--) begin
			load[k] = !v_q[k] || load[k+1];
		end
	end

	assign in_stall = !load[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (load[1]) begin
				v_q[1] <= in_valid;
			end
			for (int k = 2; k <= 6; k++) begin
				if (load[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	rbst_lane u_lane_x (
		.clk(clk), .lo(in_data.box_min_x), .hi(in_data.box_max_x),
		.origin(origin_x_q), .inv_dir(inv_dir_x_q), .en(load[5:1]), .slab(sx)
	);
	rbst_lane u_lane_y (
		.clk(clk), .lo(in_data.box_min_y), .hi(in_data.box_max_y),
		.origin(origin_y_q), .inv_dir(inv_dir_y_q), .en(load[5:1]), .slab(sy)
	);
	rbst_lane u_lane_z (
		.clk(clk), .lo(in_data.box_min_z), .hi(in_data.box_max_z),
		.origin(origin_z_q), .inv_dir(inv_dir_z_q), .en(load[5:1]), .slab(sz)
	);

	always_comb begin
		far_xy     = fp_lt(sx.t_far, sy.t_far) ? sx.t_far : sy.t_far;
		far_all    = fp_lt(far_xy, sz.t_far) ? far_xy : sz.t_far;
		near_xy    = fp_lt(sy.t_near, sx.t_near) ? sx.t_near : sy.t_near;
		near_all   = fp_lt(sz.t_near, near_xy) ? near_xy : sz.t_near;
		res.hit    = !fp_lt(far_all, FP_ZERO) && !fp_lt(far_all, near_all);
		res.t_near = near_all;
	end

	always_ff @(posedge clk) begin
		if (load[6]) begin
			out_s6 <= res;
		end
	end

	assign out_valid = v_q[6];
	assign out_data  = out_s6;

	`RBST_ASSERT(a_stall_full, clk, arst_n, in_stall |-> (v_q == 6'b111111),
		"input stalled while the pipeline has a free stage")
	`RBST_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && out_stall, out_valid,
		"stalled result was dropped")
	`RBST_ASSERT(a_no_nan_out, clk, arst_n,
		out_valid |-> ((out_data.t_near[30:23] != 8'hFF) || (out_data.t_near[22:0] == 23'd0)),
		"entry parameter is NaN")

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the ray against axis-aligned box slab test.
`timescale 1ns / 1ps

module tb_top;
	import rbst_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	box_t        in_data;
	logic        out_valid;
	logic        out_stall;
	res_t        out_data;

	ray_box_slab_test_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 8;
	localparam int BOXES_PER_PHASE = 210;

	logic [31:0] ray_origin [3];
	logic [31:0] ray_inv_dir [3];
	box_t        pending_boxes [$];
	res_t        expected_hits [$];
	int          error_count;
	int          box_count;
	int          hit_count;
	int          cycle_count;
	bit          send_gaps;
	bit          recv_stalls;
	int          gap_left;
	int          stall_left;

	always #1 clk = ~clk;

	function automatic bit f32_is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic bit f32_is_inf(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	// Rounds sign * mag * 2^k to binary32, nearest even, subnormals kept.
	function automatic logic [31:0] f32_round(input logic s, input logic [127:0] mag,
			input int k);
		int p;
		int sh;
		int e;
		logic [127:0] q;
		logic [127:0] rem;
		logic [127:0] half;
		p = 0;
		for (int i = 0; i < 128; i++) begin
			if (mag[i]) p = i;
		end
		sh = p - 23;
		if (sh < -149 - k) sh = -149 - k;
		if (sh > 127) begin
			q = '0;
		end else if (sh > 0) begin
			q = mag >> sh;
			rem = mag & ((128'd1 << sh) - 128'd1);
			half = 128'd1 << (sh - 1);
			if (rem > half || (rem == half && q[0])) q = q + 128'd1;
			if (q[24]) begin
				q = q >> 1;
				sh = sh + 1;
			end
		end else begin
			q = mag << (-sh);
		end
		e = sh + k + 150;
		if (!q[23]) return {s, 8'd0, q[22:0]};
		if (e >= 255) return {s, 8'hFF, 23'd0};
		return {s, e[7:0], q[22:0]};
	endfunction

	function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] x;
		logic [31:0] y;
		logic [127:0] mx;
		logic [127:0] my;
		logic [127:0] r;
		logic s;
		int ex;
		int ey;
		int d;
		if (f32_is_nan(a) || f32_is_nan(b)) return FP_QNAN;
		if (f32_is_inf(a) && f32_is_inf(b)) return (a[31] == b[31]) ? a : FP_QNAN;
		if (f32_is_inf(a)) return a;
		if (f32_is_inf(b)) return b;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
		if (a[30:23] >= b[30:23]) begin
			x = a;
			y = b;
		end else begin
			x = b;
			y = a;
		end
		ex = (x[30:23] == 8'd0) ? 1 : int'(x[30:23]);
		ey = (y[30:23] == 8'd0) ? 1 : int'(y[30:23]);
		mx = {104'd0, x[30:23] != 8'd0, x[22:0]} << 40;
		my = {104'd0, y[30:23] != 8'd0, y[22:0]};
		d = ex - ey;
		if (d > 40) my = (my != '0) ? 128'd1 : 128'd0;
		else my = (my << 40) >> d;
		if (x[31] == y[31]) begin
			r = mx + my;
			s = x[31];
		end else if (mx > my) begin
			r = mx - my;
			s = x[31];
		end else if (my > mx) begin
			r = my - mx;
			s = y[31];
		end else begin
			return FP_ZERO;
		end
		return f32_round(s, r, ex - 190);
	endfunction

	function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
		logic s;
		logic [127:0] ma;
		logic [127:0] mb;
		int ea;
		int eb;
		s = a[31] ^ b[31];
		if (f32_is_nan(a) || f32_is_nan(b)) return FP_QNAN;
		if ((f32_is_inf(a) && b[30:0] == 31'd0) || (f32_is_inf(b) && a[30:0] == 31'd0))
			return FP_QNAN;
		if (f32_is_inf(a) || f32_is_inf(b)) return {s, 8'hFF, 23'd0};
		if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
		ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
		ma = {104'd0, a[30:23] != 8'd0, a[22:0]};
		mb = {104'd0, b[30:23] != 8'd0, b[22:0]};
		return f32_round(s, ma * mb, ea + eb - 300);
	endfunction

	// Strict IEEE less-than; false when either side is NaN.
	function automatic bit f32_lt(input logic [31:0] a, input logic [31:0] b);
		if (f32_is_nan(a) || f32_is_nan(b)) return 1'b0;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
		if (a[31] != b[31]) return a[31];
		if (!a[31]) return a[30:0] < b[30:0];
		return a[30:0] > b[30:0];
	endfunction

	function automatic logic [31:0] f32_min(input logic [31:0] a, input logic [31:0] b);
		return f32_lt(a, b) ? a : b;
	endfunction

	function automatic logic [31:0] f32_max(input logic [31:0] a, input logic [31:0] b);
		return f32_lt(b, a) ? a : b;
	endfunction

	function automatic void axis_interval(input logic [31:0] lo, input logic [31:0] hi,
			input int axis, output logic [31:0] t_far, output logic [31:0] t_near);
		logic [31:0] p1;
		logic [31:0] p2;
		p1 = f32_mul(f32_add(lo, {~ray_origin[axis][31], ray_origin[axis][30:0]}),
			ray_inv_dir[axis]);
		p2 = f32_mul(f32_add(hi, {~ray_origin[axis][31], ray_origin[axis][30:0]}),
			ray_inv_dir[axis]);
		t_far = f32_max(f32_min(p1, FP_POS_INF), f32_min(p2, FP_POS_INF));
		t_near = f32_min(f32_max(p1, FP_NEG_INF), f32_max(p2, FP_NEG_INF));
	endfunction

	function automatic res_t box_intersect(input box_t b);
		logic [31:0] fx, nx, fy, ny, fz, nz, t_far, t_near;
		res_t r;
		axis_interval(b.box_min_x, b.box_max_x, 0, fx, nx);
		axis_interval(b.box_min_y, b.box_max_y, 1, fy, ny);
		axis_interval(b.box_min_z, b.box_max_z, 2, fz, nz);
		t_far = f32_min(f32_min(fx, fy), fz);
		t_near = f32_max(f32_max(nx, ny), nz);
		r.hit = !f32_lt(t_far, FP_ZERO) && !f32_lt(t_far, t_near);
		r.t_near = t_near;
		return r;
	endfunction

	function automatic logic [31:0] rand_f32();
		logic [31:0] specials [11];
		specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h807F_FFFF,
			32'h0080_0000, 32'hFFFF_FFFF};
		case ($urandom_range(0, 9))
			0: return specials[$urandom_range(0, 10)];
			1, 2: return $urandom;
			default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
		endcase
	endfunction

	// Mostly boxes placed so that min and max are ordered.
	function automatic box_t rand_box();
		box_t b;
		logic [31:0] lo [3];
		logic [31:0] hi [3];
		for (int i = 0; i < 3; i++) begin
			lo[i] = rand_f32();
			hi[i] = rand_f32();
			if ($urandom_range(0, 3) != 0 && f32_lt(hi[i], lo[i])) begin
				hi[i] = lo[i] ^ 32'h0;
				lo[i] = rand_f32();
				if (f32_lt(hi[i], lo[i])) lo[i] = {~hi[i][31], hi[i][30:0]};
			end
		end
		b.box_min_x = lo[0];
		b.box_min_y = lo[1];
		b.box_min_z = lo[2];
		b.box_max_x = hi[0];
		b.box_max_y = hi[1];
		b.box_max_z = hi[2];
		return b;
	endfunction

	function automatic box_t make_box(input logic [31:0] x0, input logic [31:0] y0,
			input logic [31:0] z0, input logic [31:0] x1, input logic [31:0] y1,
			input logic [31:0] z1);
		box_t b;
		b = {x0, y0, z0, x1, y1, z1};
		return b;
	endfunction

	task automatic queue_box(input box_t b);
		pending_boxes.insert(pending_boxes.size(), b);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ORIGIN_X: ray_origin[0] = value;
			REG_ORIGIN_Y: ray_origin[1] = value;
			REG_ORIGIN_Z: ray_origin[2] = value;
			REG_INV_DIR_X: ray_inv_dir[0] = value;
			REG_INV_DIR_Y: ray_inv_dir[1] = value;
			REG_INV_DIR_Z: ray_inv_dir[2] = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Waits at the falling edge, when every clocked update has settled, until all boxes are sent and checked.
	task automatic drain_pipeline();
		while (pending_boxes.size() != 0 || in_valid || expected_hits.size() != 0)
			@(negedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Driver: one box per transfer, random gaps between boxes when send_gaps is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_hits.insert(expected_hits.size(), box_intersect(in_data));
				box_count++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_boxes.size() != 0) begin
					in_data <= pending_boxes.pop_front();
					in_valid <= 1'b1;
					gap_left <= send_gaps ? $urandom_range(0, 14) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer and stalls at random when recv_stalls is set.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		int next_stall;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			next_stall = stall_left;
			if (out_valid && !out_stall) begin
				if (expected_hits.size() == 0) begin
					$error("unexpected result transfer: hit=%0b t_near=%h",
						out_data.hit, out_data.t_near);
					error_count++;
				end else begin
					want = expected_hits.pop_front();
					if (out_data.hit !== want.hit) begin
						$error("hit: expected %0b, got %0b", want.hit, out_data.hit);
						error_count++;
					end
					if (out_data.t_near !== want.t_near) begin
						$error("t_near: expected %h, got %h", want.t_near, out_data.t_near);
						error_count++;
					end
					if (want.hit) hit_count++;
				end
				next_stall = recv_stalls ? $urandom_range(0, 14) : 0;
			end else if (next_stall > 0) begin
				next_stall = next_stall - 1;
			end
			stall_left <= next_stall;
			out_stall <= (next_stall != 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ray_box_slab_test_top verification failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		box_count = 0;
		hit_count = 0;
		cycle_count = 0;
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		for (int i = 0; i < 3; i++) begin
			ray_origin[i] = FP_ZERO;
			ray_inv_dir[i] = FP_ZERO;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset ray: zero direction times an infinite corner gives NaN products.
		queue_box(make_box(FP_NEG_INF, FP_ZERO, 32'h8000_0000,
			FP_POS_INF, FP_ZERO, 32'h0000_0001));
		queue_box(make_box(FP_QNAN, FP_QNAN, FP_QNAN, FP_QNAN, FP_QNAN, FP_QNAN));
		drain_pipeline();

		write_reg(REG_ORIGIN_X, 32'h3F80_0000);
		write_reg(REG_ORIGIN_Y, FP_ZERO);
		write_reg(REG_ORIGIN_Z, 32'h8000_0000);
		write_reg(REG_INV_DIR_X, FP_POS_INF);
		write_reg(REG_INV_DIR_Y, 32'h3F80_0000);
		write_reg(REG_INV_DIR_Z, FP_NEG_INF);
		write_reg(3'd6, 32'hDEAD_BEEF);
		write_reg(3'd7, 32'h1234_5678);
		// Origin on a slab face, inside, outside, behind, NaN and extreme corners.
		queue_box(make_box(32'h3F80_0000, 32'hBF80_0000, 32'hBF80_0000,
			32'h4000_0000, 32'h3F80_0000, 32'h3F80_0000));
		queue_box(make_box(FP_ZERO, 32'hBF80_0000, 32'hBF80_0000,
			32'h4000_0000, 32'h3F80_0000, 32'h3F80_0000));
		queue_box(make_box(32'h4000_0000, 32'h4000_0000, 32'hBF80_0000,
			32'h4040_0000, 32'h4040_0000, 32'h3F80_0000));
		queue_box(make_box(32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'hFF7F_FFFF,
			32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF));
		queue_box(make_box(32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000,
			32'h0000_0002, 32'h007F_FFFF, 32'h8080_0000));
		queue_box(make_box(32'hFFC0_0001, 32'h7FFF_FFFF, FP_ZERO,
			FP_QNAN, 32'hC000_0000, 32'h8000_0000));
		queue_box(make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		queue_box(make_box(FP_POS_INF, FP_NEG_INF, FP_POS_INF,
			FP_NEG_INF, FP_POS_INF, FP_NEG_INF));
		drain_pipeline();

		write_reg(REG_ORIGIN_X, 32'h7F7F_FFFF);
		write_reg(REG_ORIGIN_Y, 32'hFF7F_FFFF);
		write_reg(REG_ORIGIN_Z, 32'h0000_0001);
		write_reg(REG_INV_DIR_X, 32'h7F7F_FFFF);
		write_reg(REG_INV_DIR_Y, 32'h0000_0001);
		write_reg(REG_INV_DIR_Z, FP_QNAN);
		queue_box(make_box(32'hFF7F_FFFF, 32'h7F7F_FFFF, FP_ZERO,
			32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001));
		queue_box(make_box(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
			32'h4000_0000, 32'h4000_0000, 32'h4000_0000));
		drain_pipeline();

		for (int ph = 0; ph < PHASES; ph++) begin
			for (int r = 0; r < 6; r++) begin
				if (r >= 3 && $urandom_range(0, 4) == 0)
					write_reg(3'(r), $urandom_range(0, 1) ? FP_POS_INF : FP_NEG_INF);
				else if (ph == 0)
					write_reg(3'(r), 32'hFFFF_FFFF);
				else
					write_reg(3'(r), rand_f32());
			end
			send_gaps = (ph % 3) != 0;
			recv_stalls = (ph % 4) != 1;
			for (int i = 0; i < BOXES_PER_PHASE; i++)
				queue_box(rand_box());
			drain_pipeline();
		end

		$display("Checked %0d boxes over %0d ray settings, %0d of them hits.",
			box_count, PHASES + 3, hit_count);
		if (error_count == 0 && expected_hits.size() == 0) begin
			$display("ray_box_slab_test_top verification clean");
		end else begin
			$display("ray_box_slab_test_top verification failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rbst_pkg.sv
rtl/rbst_fsub.sv
rtl/rbst_fmul.sv
rtl/rbst_lane.sv
rtl/ray_box_slab_test_top.sv
test/tb_top.sv
